FILE: hw/rtl/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// tlnef_pkg: shared types and constants
// Payload structs, character codes and register indexes for the
// line-number / escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

	localparam int NUMBER_DIGITS_DEF = 6;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_CTRL   = 8'h40;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_PRINT  = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// classified byte: what the back end has to emit besides the number
	typedef struct packed {
		logic       num;      // emit line number field and tab
		logic       m_pfx;    // emit "M-"
		logic       has_pre;  // emit pre before main
		logic [7:0] pre;
		logic [7:0] main;
	} chr_t;

endpackage

FILE: hw/rtl/tlnef_queue.sv
// ----------------------------------------------------------------------------
// tlnef_queue: small register FIFO
// Decouples the classifying front end from the expanding back end.
// ----------------------------------------------------------------------------
module tlnef_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         nonempty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/tlnef_front.sv
// ----------------------------------------------------------------------------
// tlnef_front: input acceptance and byte classification
// Holds the configuration and line state, numbers lines and encodes each
// byte into a descriptor for the back end.
// ----------------------------------------------------------------------------
module tlnef_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tlnef_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [tlnef_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  tlnef_pkg::in_item_t                   in_data,
	input  logic                                  q_full,
	output logic                                  q_push,
	output tlnef_pkg::chr_t                       q_chr,
	output logic [4*NUMBER_DIGITS-1:0]            q_count
);
	import tlnef_pkg::*;

	localparam int CW = 4 * NUMBER_DIGITS;

	// saturating BCD increment
	function automatic logic [CW-1:0] bcd_inc(input logic [CW-1:0] v);
		logic [CW-1:0] r;
		logic          all_nines;
		logic          carry;
		r         = v;
		all_nines = 1'b1;
		carry     = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd9) all_nines = 1'b0;
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (carry) begin
				if (v[4*i +: 4] >= 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = v[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return all_nines ? v : r;
	endfunction

	logic [1:0]    number_mode_q;
	logic          squeeze_blank_q;
	logic          show_ends_q;
	logic          show_tabs_q;
	logic          show_np_q;
	logic [CW-1:0] count_q;
	logic          last_blank_q;
	logic          at_start_q;

	logic          accept;
	logic          line_start;
	logic          is_lf;
	logic          blank;
	logic          squeeze;
	logic          num;
	logic [7:0]    low;
	logic [CW-1:0] count_nxt;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign line_start = in_data.file_start || at_start_q;
	assign is_lf      = (in_data.in_byte == CH_LF);
	assign blank      = is_lf && line_start;
	assign squeeze    = squeeze_blank_q && blank && last_blank_q;
	// mode 3 acts as mode 2
	assign num        = !squeeze && line_start && (number_mode_q != 2'd0)
		&& !(blank && number_mode_q[1]);
	assign count_nxt  = num ? bcd_inc(count_q) : count_q;

	assign q_push  = accept && !squeeze;
	assign q_count = count_nxt;

	always_comb begin
		q_chr         = '0;
		q_chr.num     = num;
		q_chr.m_pfx   = show_np_q && in_data.in_byte[7];
		low           = q_chr.m_pfx ? {1'b0, in_data.in_byte[6:0]} : in_data.in_byte;
		q_chr.main    = low;
		if (low == CH_LF) begin
			q_chr.has_pre = show_ends_q;
			q_chr.pre     = CH_DOLLAR;
		end else if (low == CH_TAB) begin
			q_chr.has_pre = show_tabs_q;
			q_chr.pre     = CH_CARET;
			q_chr.main    = show_tabs_q ? CH_I : CH_TAB;
		end else if (show_np_q && low == CH_DEL) begin
			q_chr.has_pre = 1'b1;
			q_chr.pre     = CH_CARET;
			q_chr.main    = CH_QUEST;
		end else if (show_np_q && low < CH_PRINT) begin
			q_chr.has_pre = 1'b1;
			q_chr.pre     = CH_CARET;
			q_chr.main    = low + CH_CTRL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q   <= '0;
			squeeze_blank_q <= 1'b0;
			show_ends_q     <= 1'b0;
			show_tabs_q     <= 1'b0;
			show_np_q       <= 1'b0;
			count_q         <= '0;
			last_blank_q    <= 1'b0;
			at_start_q      <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_NUMBER_MODE:      number_mode_q   <= cfg_wdata[1:0];
					CFG_SQUEEZE_BLANK:    squeeze_blank_q <= cfg_wdata[0];
					CFG_SHOW_ENDS:        show_ends_q     <= cfg_wdata[0];
					CFG_SHOW_TABS:        show_tabs_q     <= cfg_wdata[0];
					CFG_SHOW_NONPRINTING: show_np_q       <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (accept) begin
				count_q    <= count_nxt;
				at_start_q <= is_lf;
				if (!squeeze) last_blank_q <= blank;
			end
		end
	end

endmodule

FILE: hw/rtl/tlnef_back.sv
// ----------------------------------------------------------------------------
// tlnef_back: output expansion
// Expands one descriptor into its output bytes, one per cycle unless the
// output stalls, into the output register.
// ----------------------------------------------------------------------------
module tlnef_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  tlnef_pkg::chr_t            q_chr,
	input  logic [4*NUMBER_DIGITS-1:0] q_count,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tlnef_pkg::out_item_t       out_data
);
	import tlnef_pkg::*;

	localparam int CW = 4 * NUMBER_DIGITS;
	localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
	localparam logic [DW-1:0] DIG_TOP = DW'(NUMBER_DIGITS - 1);

	typedef enum logic [2:0] {
		PH_DIG,
		PH_TAB,
		PH_M,
		PH_DASH,
		PH_PRE,
		PH_MAIN
	} phase_t;

	logic          active_q;
	chr_t          job_chr_q;
	logic [CW-1:0] job_cnt_q;
	phase_t        phase_q;
	logic [DW-1:0] dig_q;
	logic          seen_q;
	logic          out_valid_q;
	out_item_t     out_q;

	chr_t          src_chr;
	logic [CW-1:0] src_cnt;
	phase_t        start_ph;
	phase_t        cur_ph;
	phase_t        nxt_ph;
	phase_t        chr_ph;
	logic [DW-1:0] cur_dig;
	logic          cur_seen;
	logic [3:0]    digit;
	logic          show;
	logic          load;
	logic          emit;
	logic          is_last;
	logic [7:0]    byte_nxt;

	assign src_chr  = active_q ? job_chr_q : q_chr;
	assign src_cnt  = active_q ? job_cnt_q : q_count;
	assign chr_ph   = src_chr.m_pfx ? PH_M : (src_chr.has_pre ? PH_PRE : PH_MAIN);
	assign start_ph = src_chr.num ? PH_DIG : chr_ph;
	assign cur_ph   = active_q ? phase_q : start_ph;
	assign cur_dig  = active_q ? dig_q : DIG_TOP;
	assign cur_seen = active_q && seen_q;
	assign digit    = src_cnt[4*cur_dig +: 4];
	assign show     = cur_seen || (digit != 4'd0) || (cur_dig == '0);
	assign load     = !out_valid_q || out_ready;
	assign emit     = load && (active_q || q_valid);
	assign is_last  = (cur_ph == PH_MAIN);
	assign q_pop    = emit && !active_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		case (cur_ph)
			PH_DIG: begin
				byte_nxt = show ? (CH_ZERO + {4'd0, digit}) : CH_SPACE;
				nxt_ph   = (cur_dig == '0) ? PH_TAB : PH_DIG;
			end
			PH_TAB: begin
				byte_nxt = CH_TAB;
				nxt_ph   = chr_ph;
			end
			PH_M: begin
				byte_nxt = CH_M;
				nxt_ph   = PH_DASH;
			end
			PH_DASH: begin
				byte_nxt = CH_DASH;
				nxt_ph   = src_chr.has_pre ? PH_PRE : PH_MAIN;
			end
			PH_PRE: begin
				byte_nxt = src_chr.pre;
				nxt_ph   = PH_MAIN;
			end
			PH_MAIN: begin
				byte_nxt = src_chr.main;
				nxt_ph   = PH_MAIN;
			end
			default: begin
				byte_nxt = src_chr.main;
				nxt_ph   = PH_MAIN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			job_chr_q   <= '0;
			job_cnt_q   <= '0;
			phase_q     <= PH_MAIN;
			dig_q       <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (emit) begin
			out_valid_q    <= 1'b1;
			out_q.out_byte <= byte_nxt;
			out_q.last     <= is_last;
			active_q       <= !is_last;
			phase_q        <= nxt_ph;
			dig_q          <= (cur_dig == '0) ? cur_dig : cur_dig - 1'b1;
			seen_q         <= show && (cur_ph == PH_DIG);
			if (!active_q) begin
				job_chr_q <= q_chr;
				job_cnt_q <= q_count;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/text_line_number_escape_filter_top.sv
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_top: line numbering and escape filter
// Formats a text byte stream with optional line numbers, blank-line
// squeezing and caret / M- notation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one text byte per
//   transaction, with file_start set on the first byte of each file.
//   Output channel (out_valid/out_ready/out_data) carries one formatted byte
//   per transaction; last marks the final byte produced by an input byte.
//   A squeezed blank line produces no output transaction at all.
//   Configuration: cfg_we/cfg_idx/cfg_wdata write the five option registers
//   (0 number mode, 1 squeeze, 2 show ends, 3 show tabs, 4 nonprinting);
//   write only while the filter is idle.
//   Each input byte passes through the descriptor queue and then the output
//   register before its first output byte is presented.
//   Throughput: one output byte per cycle unless the output stalls; an input
//   byte expands to 1 to NUMBER_DIGITS+5 output bytes, set by the expansion
//   sequencer in the back end. Plain bytes stream at one per cycle while unstalled.
//   A two-entry queue between classifier and expander lets input continue
//   while the output is stalled; when it fills, in_ready drops.
//   Reset clears options, line count, blank mark and sets the line start.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_top #(
	parameter int NUMBER_DIGITS = tlnef_pkg::NUMBER_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tlnef_pkg::in_item_t              in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tlnef_pkg::out_item_t             out_data
);
	import tlnef_pkg::*;

	localparam int CW = 4 * NUMBER_DIGITS;
	localparam int QW = CW + $bits(chr_t);

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_nonempty;
	chr_t          f_chr;
	logic [CW-1:0] f_count;
	chr_t          b_chr;
	logic [CW-1:0] b_count;
	logic [QW-1:0] q_rdata;

	// front: accepts and classifies bytes, keeps line state
	tlnef_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_chr    (f_chr),
		.q_count  (f_count)
	);

	// descriptor queue
	tlnef_queue #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wdata   ({f_chr, f_count}),
		.pop     (q_pop),
		.rdata   (q_rdata),
		.full    (q_full),
		.nonempty(q_nonempty)
	);

	assign b_chr   = chr_t'(q_rdata[QW-1:CW]);
	assign b_count = q_rdata[CW-1:0];

	// back: expands descriptors into output bytes
	tlnef_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_nonempty),
		.q_chr    (b_chr),
		.q_count  (b_count),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("queue underflow");

	// back end only takes a descriptor when the output slot frees up
	a_pop_on_slot: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (out_ready || !out_valid))
		else $error("pop while output stalled");

	// a popped descriptor always yields a byte in the output register
	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("pop without output");

endmodule

FILE: bench/tb_text_line_number_escape_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_line_number_escape_filter_top: self-checking bench for the filter
// Feeds text bytes through the input channel and predicts every formatted
// output byte. The prediction covers line numbers, blank-line squeezing, end
// marks and caret / M- notation. Each output transaction is checked against
// the oldest predicted byte. Options change only while the filter is idle.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_text_line_number_escape_filter_top;
	import tlnef_pkg::*;

	localparam int NDIG = NUMBER_DIGITS_DEF;

	// number_mode register values
	localparam logic [1:0] NUM_OFF      = 2'd0;
	localparam logic [1:0] NUM_ALL      = 2'd1;
	localparam logic [1:0] NUM_NONBLANK = 2'd2;
	localparam logic [1:0] NUM_MODE3    = 2'd3;  // acts as non-blank only

	// cycles allowed for an item that makes no output (squeezed blank line)
	// to leave the pipe: output register, two-entry queue, longest expansion
	localparam int SETTLE    = 40;
	localparam int DRAIN_CAP = 40000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	// idling controls, flipped by the tests
	bit in_idle_en   = 1'b0;
	bit out_stall_en = 1'b0;
	int stall_left   = 0;
	int err_cnt      = 0;

	// predictor state: options, BCD line count, blank mark, line start
	logic [1:0]        opt_number_mode;
	logic              opt_squeeze, opt_ends, opt_tabs, opt_np;
	logic [4*NDIG-1:0] line_bcd;
	logic              last_blank;
	logic              at_start;

	// formatted bytes still owed by the filter, oldest first
	out_item_t expected_bytes[$];

	text_line_number_escape_filter_top #(
		.NUMBER_DIGITS(NDIG)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		err_cnt++;
	endtask

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// next line number; saturates once every digit is nine
	function automatic logic [4*NDIG-1:0] bcd_next(input logic [4*NDIG-1:0] v);
		logic [4*NDIG-1:0] r;
		bit                all9;
		bit                carry;
		all9 = 1'b1;
		for (int i = 0; i < NDIG; i++)
			if (v[4*i +: 4] != 4'd9)
				all9 = 1'b0;
		if (all9)
			return v;
		r = v;
		carry = 1'b1;
		for (int i = 0; i < NDIG; i++) begin
			if (carry) begin
				if (r[4*i +: 4] == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = r[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Work out the output bytes of one accepted input byte and queue them.
	task automatic format_byte(input in_item_t item);
		logic [7:0] seq[$];
		logic [7:0] c;
		logic [3:0] d;
		bit         blank;
		bit         seen;
		out_item_t  e;
		c = item.in_byte;
		if (item.file_start)
			at_start = 1'b1;
		blank = (c == CH_LF) && at_start;

		// a blank line right after a printed blank line vanishes when squeezing
		if (!(opt_squeeze && blank && last_blank)) begin
			if (at_start && opt_number_mode != NUM_OFF &&
			    (!blank || !opt_number_mode[1])) begin
				line_bcd = bcd_next(line_bcd);
				seen = 1'b0;
				for (int i = NDIG - 1; i >= 0; i--) begin
					d = line_bcd[4*i +: 4];
					if (d != 4'd0 || i == 0)
						seen = 1'b1;
					seq.push_back(seen ? CH_ZERO + {4'd0, d} : CH_SPACE);
				end
				seq.push_back(CH_TAB);
			end

			// high byte: "M-" then the low seven bits by the usual rules
			if (opt_np && c[7]) begin
				seq.push_back(CH_M);
				seq.push_back(CH_DASH);
				c[7] = 1'b0;
			end
			if (c == CH_LF) begin
				if (opt_ends)
					seq.push_back(CH_DOLLAR);
				seq.push_back(CH_LF);
			end else if (c == CH_TAB) begin
				if (opt_tabs) begin
					seq.push_back(CH_CARET);
					seq.push_back(CH_I);
				end else begin
					seq.push_back(CH_TAB);
				end
			end else if (opt_np && c == CH_DEL) begin
				seq.push_back(CH_CARET);
				seq.push_back(CH_QUEST);
			end else if (opt_np && c < CH_PRINT) begin
				seq.push_back(CH_CARET);
				seq.push_back(c + CH_CTRL);
			end else begin
				seq.push_back(c);
			end
			last_blank = blank;
		end
		at_start = (item.in_byte == CH_LF);

		foreach (seq[i]) begin
			e.out_byte = seq[i];
			e.last     = (i == seq.size() - 1);
			expected_bytes.push_back(e);
		end
	endtask

	// Send one byte; called at a rising edge, returns at its acceptance edge.
	task automatic send_byte(input logic [7:0] b, input logic fs);
		in_item_t item;
		int       gap;
		item.in_byte    = b;
		item.file_start = fs;
		gap = (in_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		// ready is settled mid-cycle; the next rising edge takes the transaction
		forever begin
			@(negedge clk);
			if (in_ready)
				break;
		end
		@(posedge clk);
		format_byte(item);
	endtask

	// Stop sending, wait for every predicted byte, then let the pipe settle.
	task automatic wait_idle();
		int n;
		in_valid <= 1'b0;
		for (n = 0; n < DRAIN_CAP && expected_bytes.size() != 0; n++)
			@(posedge clk);
		if (expected_bytes.size() != 0) begin
			report_mismatch($sformatf("%0d output bytes never arrived",
				expected_bytes.size()));
			expected_bytes.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all five option registers; only while idle.
	task automatic write_options(input logic [1:0] mode, input logic sq,
	                             input logic ends, input logic tabs,
	                             input logic np);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_NUMBER_MODE;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_idx   <= CFG_SQUEEZE_BLANK;
		cfg_wdata <= {1'b0, sq};
		@(posedge clk);
		cfg_idx   <= CFG_SHOW_ENDS;
		cfg_wdata <= {1'b0, ends};
		@(posedge clk);
		cfg_idx   <= CFG_SHOW_TABS;
		cfg_wdata <= {1'b0, tabs};
		@(posedge clk);
		cfg_idx   <= CFG_SHOW_NONPRINTING;
		cfg_wdata <= {1'b0, np};
		@(posedge clk);
		cfg_we    <= 1'b0;
		opt_number_mode = mode;
		opt_squeeze     = sq;
		opt_ends        = ends;
		opt_tabs        = tabs;
		opt_np          = np;
	endtask

	// Text-like byte: many line ends and tabs, some control and high bytes.
	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22) return CH_LF;
		if (r < 30) return CH_TAB;
		if (r < 42) return 8'($urandom_range(0, 255));
		if (r < 50) return 8'($urandom_range(128, 255));
		if (r < 55) return 8'($urandom_range(0, 31));
		return 8'($urandom_range(32, 126));
	endfunction

	// ------------------------------------------------------------------------
	// Output side: random backpressure
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (out_stall_en && $urandom_range(0, 99) < 30) begin
			out_ready <= 1'b0;
			stall_left = idle_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Checker: sampled mid-cycle, so valid/ready/data are those of the
	// transaction taken at the coming rising edge.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected output byte %02h",
					out_data.out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte got %02h want %02h",
						out_data.out_byte, want.out_byte));
				if (out_data.last !== want.last)
					report_mismatch($sformatf("last got %0b want %0b (byte %02h)",
						out_data.last, want.last, want.out_byte));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset options: everything raw, only tab and newline special.
	task automatic test_plain_defaults();
		send_byte(8'h41, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_LF, 1'b0);
		wait_idle();
	endtask

	// All options on: numbering every line, squeeze, ends, tabs, notation.
	task automatic test_notation_all_on();
		write_options(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
		send_byte(8'h78, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(CH_DEL, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h8A, 1'b0);   // M- then a shown line end
		send_byte(8'h89, 1'b0);   // M-^I
		send_byte(8'hFF, 1'b0);   // M-^?
		send_byte(CH_LF, 1'b0);
		send_byte(CH_LF, 1'b0);   // blank line, numbered
		send_byte(CH_LF, 1'b0);   // second blank: squeezed, no output
		send_byte(CH_SPACE, 1'b0);
		wait_idle();
	endtask

	// Mode three numbers non-blank lines only; raw tab with notation on.
	task automatic test_nonblank_numbering();
		write_options(NUM_MODE3, 1'b0, 1'b0, 1'b0, 1'b1);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);   // new file restarts the line
		send_byte(CH_LF, 1'b0);
		wait_idle();
	endtask

	// Many short lines so the count carries into the hundreds.
	task automatic test_count_carry();
		write_options(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < 110; i++)
			send_byte((i % 8 == 7) ? 8'h7A : CH_LF, 1'b0);
		wait_idle();
	endtask

	// Random text in phases, each under its own options.
	task automatic test_random_text();
		logic [1:0] mode;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_options(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
				end
				1: begin
					write_options(NUM_MODE3, 1'b1, 1'b1, 1'b1, 1'b1);
				end
				3: begin
					write_options(NUM_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b0);
				end
				default: begin
					mode = 2'($urandom_range(0, 3));
					write_options(mode, 1'($urandom), 1'($urandom),
						1'($urandom), 1'($urandom));
				end
			endcase
			// one phase runs flat out with no idling on either side
			in_idle_en   = (ph != 2);
			out_stall_en = (ph != 2);
			for (int i = 0; i < 13; i++) begin
				send_byte(text_byte(), ($urandom_range(0, 99) < 5));
				// now and then hold the input until the output has caught up
				if ($urandom_range(0, 99) < 3)
					wait_idle();
			end
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		opt_number_mode = NUM_OFF;
		opt_squeeze     = 1'b0;
		opt_ends        = 1'b0;
		opt_tabs        = 1'b0;
		opt_np          = 1'b0;
		line_bcd        = '0;
		last_blank      = 1'b0;
		at_start        = 1'b1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_en   = 1'b1;
		out_stall_en = 1'b1;
		test_plain_defaults();
		test_notation_all_on();
		test_nonblank_numbering();

		in_idle_en   = 1'b0;
		out_stall_en = 1'b0;
		test_count_carry();

		test_random_text();
		wait_idle();

		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/tlnef_pkg.sv
hw/rtl/tlnef_queue.sv
hw/rtl/tlnef_front.sv
hw/rtl/tlnef_back.sv
hw/rtl/text_line_number_escape_filter_top.sv
bench/tb_text_line_number_escape_filter_top.sv
